// ===== rtl/pps_pkg.sv =====
// Shared types and constants for the print position sequencer.
// No dependencies; imported by every module of the block.
package pps_pkg;

  // Default widths of the internal page/copy and scan counters
  localparam int PAGE_BITS_DEF = 16;
  localparam int SCAN_BITS_DEF = 20;

  // Field widths of the stream items
  localparam int ID_W   = 16;
  localparam int PAGE_W = 16;
  localparam int SCAN_W = 20;
  localparam int TDATA_W = 72;  // 68 bits of fields padded to whole bytes

  // Divider widths: |scan - start| * copy_count < 2**36, |total - start| < 2**20
  localparam int NUM_W = 36;
  localparam int DEN_W = 20;

  // Configuration port
  localparam int CFG_ADDR_W = 5;
  localparam int CFG_DATA_W = 32;

  localparam logic [2:0] REG_MODE        = 3'd0;
  localparam logic [2:0] REG_LEN_COPIES  = 3'd1;
  localparam logic [2:0] REG_TOTAL_SCANS = 3'd2;
  localparam logic [2:0] REG_START_SCANS = 3'd3;
  localparam logic [2:0] REG_COPY_COUNT  = 3'd4;
  localparam logic [2:0] REG_FIRST_PAGE  = 3'd5;
  localparam logic [2:0] REG_LAST_PAGE   = 3'd6;

  localparam logic [1:0] MODE_WEB_UNCOLL  = 2'd0;
  localparam logic [1:0] MODE_WEB_COLL    = 2'd1;
  localparam logic [1:0] MODE_SCAN_SINGLE = 2'd2;
  localparam logic [1:0] MODE_SCAN_MULTI  = 2'd3;

  typedef struct packed {
    logic [1:0]        mode;
    logic              length_in_copies;
    logic [SCAN_W-1:0] total_scans;
    logic [SCAN_W-1:0] start_scans;
    logic [PAGE_W-1:0] copy_count;
    logic [PAGE_W-1:0] first_page_no;
    logic [PAGE_W-1:0] last_page_no;
  } pps_cfg_t;

  // Side information that travels alongside the divider data
  typedef struct packed {
    logic [ID_W-1:0]   job_id;
    logic [PAGE_W-1:0] page;
    logic [SCAN_W-1:0] scan;
    logic              use_div;   // derived copy applies to this item
    logic              neg;       // quotient sign is negative
  } pps_meta_t;

endpackage

// ===== rtl/pps_front.sv =====
// Front end: mode decode into the base next position, then the
// (scan - start) * copy_count product. Two register stages. Uses pps_pkg.
module pps_front #(
  parameter int PAGE_BITS = pps_pkg::PAGE_BITS_DEF,
  parameter int SCAN_BITS = pps_pkg::SCAN_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  pps_pkg::pps_cfg_t            cfg,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [pps_pkg::ID_W-1:0]     job_id,
  input  logic [pps_pkg::PAGE_W-1:0]   current_page,
  input  logic [pps_pkg::PAGE_W-1:0]   current_copy,
  input  logic [pps_pkg::SCAN_W-1:0]   current_scan,
  output logic                         out_valid,
  input  logic                         out_ready,
  output pps_pkg::pps_meta_t           out_meta,
  output logic [PAGE_BITS-1:0]         out_copy,
  output logic [pps_pkg::NUM_W-1:0]    out_num
);
  import pps_pkg::*;

  localparam int SCW = (SCAN_BITS > SCAN_W) ? SCAN_BITS : SCAN_W;
  localparam int PCW = (PAGE_BITS > PAGE_W) ? PAGE_BITS : PAGE_W;

  logic [PAGE_BITS-1:0] page, copy, first, page_inc, copy_inc;
  logic [SCAN_BITS-1:0] scan, scan_inc;
  logic [PAGE_BITS-1:0] n_page, n_copy;
  logic [SCAN_BITS-1:0] n_scan;
  logic                 scan_lt_total, use_div;
  logic [SCAN_W:0]      diff, span;
  logic [DEN_W-1:0]     mag;
  pps_meta_t            meta;

  logic                 a_valid_r, b_valid_r, a_ready, b_ready;
  pps_meta_t            a_meta_r, b_meta_r;
  logic [PAGE_BITS-1:0] a_copy_r, b_copy_r;
  logic [DEN_W-1:0]     a_mag_r;
  logic [NUM_W-1:0]     b_num_r;

  assign page  = PAGE_BITS'(current_page);
  assign copy  = PAGE_BITS'(current_copy);
  assign first = PAGE_BITS'(cfg.first_page_no);
  assign scan  = SCAN_BITS'(current_scan);

  assign page_inc = (page == '1) ? page : page + PAGE_BITS'(1);
  assign copy_inc = (copy == '1) ? copy : copy + PAGE_BITS'(1);
  assign scan_inc = (scan == '1) ? scan : scan + SCAN_BITS'(1);
  assign scan_lt_total = SCW'(scan) < SCW'(cfg.total_scans);

  always_comb begin
    n_page  = page;
    n_copy  = copy;
    n_scan  = SCAN_BITS'(1);
    use_div = 1'b0;
    case (cfg.mode)
      MODE_SCAN_MULTI: begin
        n_copy = PAGE_BITS'(1);
        if (scan_lt_total) begin
          n_scan = scan_inc;
        end else begin
          n_page = page_inc;
          n_scan = '0;
        end
      end
      MODE_SCAN_SINGLE: begin
        if (scan_lt_total) begin
          n_scan  = scan_inc;
          use_div = cfg.length_in_copies && (cfg.total_scans != cfg.start_scans)
                    && (cfg.copy_count != '0);
        end else begin
          n_copy = copy_inc;
        end
      end
      MODE_WEB_COLL: begin
        if ((PCW+1)'(page) + (PCW+1)'(1) <= (PCW+1)'(cfg.last_page_no)) begin
          n_page = page_inc;
        end else begin
          n_copy = copy_inc;
          n_page = first;
        end
      end
      default: begin
        if (cfg.copy_count != '0) begin
          if (PCW'(copy) < PCW'(cfg.copy_count)) begin
            n_copy = copy_inc;
          end else begin
            n_copy = PAGE_BITS'(1);
            n_page = page_inc;
          end
        end
      end
    endcase
  end

  // Signed operands of the derived copy; scan fits the 20-bit field by construction
  assign diff = {1'b0, SCAN_W'(scan)} - {1'b0, cfg.start_scans};
  assign span = {1'b0, cfg.total_scans} - {1'b0, cfg.start_scans};
  assign mag  = diff[SCAN_W] ? DEN_W'(-diff) : DEN_W'(diff);

  always_comb begin
    meta.job_id  = job_id;
    meta.page    = PAGE_W'(n_page);
    meta.scan    = SCAN_W'(n_scan);
    meta.use_div = use_div;
    meta.neg     = diff[SCAN_W] ^ span[SCAN_W];
  end

  assign b_ready  = !b_valid_r || out_ready;
  assign a_ready  = !a_valid_r || b_ready;
  assign in_ready = a_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_valid_r <= 1'b0;
      b_valid_r <= 1'b0;
    end else begin
      if (a_ready) a_valid_r <= in_valid;
      if (b_ready) b_valid_r <= a_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (a_ready && in_valid) begin
      a_meta_r <= meta;
      a_copy_r <= n_copy;
      a_mag_r  <= mag;
    end
    if (b_ready && a_valid_r) begin
      b_meta_r <= a_meta_r;
      b_copy_r <= a_copy_r;
      b_num_r  <= NUM_W'(a_mag_r) * NUM_W'(cfg.copy_count);
    end
  end

  assign out_valid = b_valid_r;
  assign out_meta  = b_meta_r;
  assign out_copy  = b_copy_r;
  assign out_num   = b_num_r;

endmodule

// ===== rtl/pps_div_cell.sv =====
// One cell of the restoring divider chain: one quotient bit per cell.
// Quotient bits shift into the low end as numerator bits leave the top. Uses pps_pkg.
module pps_div_cell #(
  parameter int PAGE_BITS = pps_pkg::PAGE_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pps_pkg::DEN_W-1:0] den,
  input  logic                      up_valid,
  output logic                      up_ready,
  input  pps_pkg::pps_meta_t        up_meta,
  input  logic [PAGE_BITS-1:0]      up_copy,
  input  logic [pps_pkg::DEN_W-1:0] up_rem,
  input  logic [pps_pkg::NUM_W-1:0] up_nq,
  output logic                      dn_valid,
  input  logic                      dn_ready,
  output pps_pkg::pps_meta_t        dn_meta,
  output logic [PAGE_BITS-1:0]      dn_copy,
  output logic [pps_pkg::DEN_W-1:0] dn_rem,
  output logic [pps_pkg::NUM_W-1:0] dn_nq
);
  import pps_pkg::*;

  logic                 valid_r;
  pps_meta_t            meta_r;
  logic [PAGE_BITS-1:0] copy_r;
  logic [DEN_W-1:0]     rem_r, rem_nxt;
  logic [NUM_W-1:0]     nq_r;
  logic [DEN_W:0]       trial;
  logic                 qbit;

  assign trial   = {up_rem, up_nq[NUM_W-1]};
  assign qbit    = trial >= {1'b0, den};
  assign rem_nxt = qbit ? DEN_W'(trial - {1'b0, den}) : DEN_W'(trial);

  assign up_ready = !valid_r || dn_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) begin
      meta_r <= up_meta;
      copy_r <= up_copy;
      rem_r  <= rem_nxt;
      nq_r   <= {up_nq[NUM_W-2:0], qbit};
    end
  end

  assign dn_valid = valid_r;
  assign dn_meta  = meta_r;
  assign dn_copy  = copy_r;
  assign dn_rem   = rem_r;
  assign dn_nq    = nq_r;

endmodule

// ===== rtl/pps_back.sv =====
// Back end: applies the derived copy from the quotient and holds the result
// in the output register. Uses pps_pkg.
module pps_back #(
  parameter int PAGE_BITS = pps_pkg::PAGE_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        up_valid,
  output logic                        up_ready,
  input  pps_pkg::pps_meta_t          up_meta,
  input  logic [PAGE_BITS-1:0]        up_copy,
  input  logic [pps_pkg::NUM_W-1:0]   up_quo,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [pps_pkg::TDATA_W-1:0] out_data
);
  import pps_pkg::*;

  localparam logic [PAGE_BITS-1:0] PAGE_MAX = '1;

  logic                 replace, nonneg, quo_sat;
  logic [PAGE_BITS-1:0] derived, n_copy;
  logic                 valid_r;
  logic [TDATA_W-1:0]   data_r, data_nxt;

  // a zero quotient counts as non-negative whatever the operand signs
  assign nonneg  = !up_meta.neg || (up_quo == '0);
  assign replace = up_meta.use_div && nonneg && (up_quo >= NUM_W'(up_copy));
  assign quo_sat = up_quo >= NUM_W'(PAGE_MAX);
  assign derived = quo_sat ? PAGE_MAX : PAGE_BITS'(up_quo) + PAGE_BITS'(1);
  assign n_copy  = replace ? derived : up_copy;

  assign data_nxt = {{(TDATA_W - ID_W - 2*PAGE_W - SCAN_W){1'b0}},
                     up_meta.scan, PAGE_W'(n_copy), up_meta.page, up_meta.job_id};

  assign up_ready = !valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready && up_valid) data_r <= data_nxt;
  end

  assign out_valid = valid_r;
  assign out_data  = data_r;

endmodule

// ===== rtl/print_position_sequencer_unit.sv =====
// Pipeline: decode, multiply, 36 divider cells, output register; one position per
// cycle sustained while out_tready does not hold the output.
// The divider chain yields one quotient bit per cell.
// Reset: synchronous, active low; clears all valid bits and loads the
// configuration registers with their defaults. No clearing pass.
module print_position_sequencer_unit #(
  parameter int PAGE_BITS = pps_pkg::PAGE_BITS_DEF,
  parameter int SCAN_BITS = pps_pkg::SCAN_BITS_DEF
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // job_id[15:0], current_page[31:16], current_copy[47:32], current_scan[67:48]
  input  logic [pps_pkg::TDATA_W-1:0]    in_tdata,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // next_job_id[15:0], next_page[31:16], next_copy[47:32], next_scan[67:48]
  output logic [pps_pkg::TDATA_W-1:0]    out_tdata,
  input  logic                           cfg_psel,
  input  logic                           cfg_penable,
  input  logic                           cfg_pwrite,
  input  logic [pps_pkg::CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [pps_pkg::CFG_DATA_W-1:0] cfg_pwdata,
  output logic [pps_pkg::CFG_DATA_W-1:0] cfg_prdata,
  output logic                           cfg_pready
);
  import pps_pkg::*;

  pps_cfg_t         cfg_r;
  logic [2:0]       reg_idx;
  logic             wr_en;
  logic [SCAN_W:0]  span;
  logic [DEN_W-1:0] den;

  assign cfg_pready = 1'b1;
  assign reg_idx    = cfg_paddr[CFG_ADDR_W-1:2];
  assign wr_en      = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mode             <= MODE_WEB_UNCOLL;
      cfg_r.length_in_copies <= 1'b0;
      cfg_r.total_scans      <= '0;
      cfg_r.start_scans      <= '0;
      cfg_r.copy_count       <= PAGE_W'(1);
      cfg_r.first_page_no    <= PAGE_W'(1);
      cfg_r.last_page_no     <= PAGE_W'(1);
    end else if (wr_en) begin
      case (reg_idx)
        REG_MODE:        cfg_r.mode             <= cfg_pwdata[1:0];
        REG_LEN_COPIES:  cfg_r.length_in_copies <= cfg_pwdata[0];
        REG_TOTAL_SCANS: cfg_r.total_scans      <= cfg_pwdata[SCAN_W-1:0];
        REG_START_SCANS: cfg_r.start_scans      <= cfg_pwdata[SCAN_W-1:0];
        REG_COPY_COUNT:  cfg_r.copy_count       <= cfg_pwdata[PAGE_W-1:0];
        REG_FIRST_PAGE:  cfg_r.first_page_no    <= cfg_pwdata[PAGE_W-1:0];
        REG_LAST_PAGE:   cfg_r.last_page_no     <= cfg_pwdata[PAGE_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_MODE:        cfg_prdata = CFG_DATA_W'(cfg_r.mode);
      REG_LEN_COPIES:  cfg_prdata = CFG_DATA_W'(cfg_r.length_in_copies);
      REG_TOTAL_SCANS: cfg_prdata = CFG_DATA_W'(cfg_r.total_scans);
      REG_START_SCANS: cfg_prdata = CFG_DATA_W'(cfg_r.start_scans);
      REG_COPY_COUNT:  cfg_prdata = CFG_DATA_W'(cfg_r.copy_count);
      REG_FIRST_PAGE:  cfg_prdata = CFG_DATA_W'(cfg_r.first_page_no);
      REG_LAST_PAGE:   cfg_prdata = CFG_DATA_W'(cfg_r.last_page_no);
      default:         cfg_prdata = '0;
    endcase
  end

  // divisor magnitude; configuration must only change while the pipe is empty, which the block does not enforce
  assign span = {1'b0, cfg_r.total_scans} - {1'b0, cfg_r.start_scans};
  assign den  = span[SCAN_W] ? DEN_W'(-span) : DEN_W'(span);

  logic                 c_valid [0:NUM_W];
  logic                 c_ready [0:NUM_W];
  pps_meta_t            c_meta  [0:NUM_W];
  logic [PAGE_BITS-1:0] c_copy  [0:NUM_W];
  logic [DEN_W-1:0]     c_rem   [0:NUM_W];
  logic [NUM_W-1:0]     c_nq    [0:NUM_W];

  assign c_rem[0] = '0;

  pps_front #(
    .PAGE_BITS (PAGE_BITS),
    .SCAN_BITS (SCAN_BITS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg_r),
    .in_valid     (in_tvalid),
    .in_ready     (in_tready),
    .job_id       (in_tdata[ID_W-1:0]),
    .current_page (in_tdata[ID_W+PAGE_W-1:ID_W]),
    .current_copy (in_tdata[ID_W+2*PAGE_W-1:ID_W+PAGE_W]),
    .current_scan (in_tdata[ID_W+2*PAGE_W+SCAN_W-1:ID_W+2*PAGE_W]),
    .out_valid    (c_valid[0]),
    .out_ready    (c_ready[0]),
    .out_meta     (c_meta[0]),
    .out_copy     (c_copy[0]),
    .out_num      (c_nq[0])
  );

  for (genvar i = 0; i < NUM_W; i++) begin : g_cell
    pps_div_cell #(
      .PAGE_BITS (PAGE_BITS)
    ) u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .den      (den),
      .up_valid (c_valid[i]),
      .up_ready (c_ready[i]),
      .up_meta  (c_meta[i]),
      .up_copy  (c_copy[i]),
      .up_rem   (c_rem[i]),
      .up_nq    (c_nq[i]),
      .dn_valid (c_valid[i+1]),
      .dn_ready (c_ready[i+1]),
      .dn_meta  (c_meta[i+1]),
      .dn_copy  (c_copy[i+1]),
      .dn_rem   (c_rem[i+1]),
      .dn_nq    (c_nq[i+1])
    );
  end

  pps_back #(
    .PAGE_BITS (PAGE_BITS)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .up_valid  (c_valid[NUM_W]),
    .up_ready  (c_ready[NUM_W]),
    .up_meta   (c_meta[NUM_W]),
    .up_copy   (c_copy[NUM_W]),
    .up_quo    (c_nq[NUM_W]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_data  (out_tdata)
  );

endmodule

// ===== rtl/pps_checker.sv =====
// Port-level checks for print_position_sequencer_unit, attached by bind.
// Depends on pps_pkg for the data width.
module pps_checker (
  input logic                        clk,
  input logic                        rst_n,
  input logic                        in_tvalid,
  input logic                        in_tready,
  input logic                        out_tvalid,
  input logic                        out_tready,
  input logic [pps_pkg::TDATA_W-1:0] out_tdata
);
  import pps_pkg::*;

  // a result waiting for transfer stays offered
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid)
    else $error("out_tvalid dropped before transfer");

  // with the output register empty the whole chain can move
  a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_tvalid |-> in_tready)
    else $error("input stalled with empty output");

  // nothing comes out straight after a reset edge
  a_reset_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result offered after reset");

  // padding above the result fields stays zero
  a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> out_tdata[TDATA_W-1:ID_W+2*PAGE_W+SCAN_W] == '0)
    else $error("padding bits set in out_tdata");

endmodule

bind print_position_sequencer_unit pps_checker u_pps_checker (.*);
